// File: rtl/btda_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds field widths, character codes, the controller state type and the
// command and status structs shared by the controller, datapath and top level.
`default_nettype none

package btda_pkg;

   // Fixed field widths of the channels.
   localparam int NUMBER_WIDTH = 32;
   localparam int TEXT_WIDTH   = 8;

   // Default number of low input bits that make up the value.
   localparam int VALUE_BITS_DEFAULT = 32;

   // Width of one packed decimal digit.
   localparam int DIGIT_WIDTH = 4;

   // Character codes: upper nibble of an ASCII digit, and the newline.
   localparam logic [3:0]            ASCII_DIGIT_HI = 4'h3;
   localparam logic [TEXT_WIDTH-1:0] ASCII_NEWLINE  = 8'h0A;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT,
      ST_NEWLINE
   } btda_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new item and clear the digits
      logic dabble;      // one double dabble step
      logic shift;       // drop the top digit
      logic newline_sel; // present the newline instead of a digit
   } btda_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bits_last;   // the current dabble step is the final one
      logic top_zero;    // the top digit is zero
      logic one_left;    // only one digit remains
   } btda_stat_type;

endpackage

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// Top level of the unsigned binary to decimal ASCII converter.
// Instantiates btda_ctrl and btda_datapath; depends on btda_pkg.
//
//   Channel   Ports                              Direction  Meaning
//   req       req_valid/req_stall, req_number    in         value to render
//   rsp       rsp_valid/rsp_stall, rsp_text_byte out        one character per item,
//             rsp_last_char                                 newline marked last
//
// An item is taken while idle, then the double dabble shifter converts the low
// VALUE_BITS bits (at most 32), one bit per cycle.
// Leading zeros are dropped at one digit per cycle, then the skip state hands over
// to the output; each digit and the newline go out at one per cycle unless stalled.
// Dropped zeros and digits always total the digit count (ten at 32 bits).
// Reset is synchronous and returns the controller to idle.
// A stall on the result channel holds the current character; no new item is
// taken until the newline of the current one has been delivered.
`default_nettype none

module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [btda_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [btda_pkg::TEXT_WIDTH-1:0]   rsp_text_byte,
   output logic                                   rsp_last_char
);

   btda_pkg::btda_cmd_type  cmd;
   btda_pkg::btda_stat_type stat;

   // Sequencer.
   btda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Conversion registers and character selection.
   btda_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .number    (req_number),
      .stat      (stat),
      .text_byte (rsp_text_byte)
   );

   // The newline is the only character that ends a run.
   assign rsp_last_char = cmd.newline_sel;

`ifndef ASSERT_OFF
   // No new item is taken while characters are being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item taken while characters are pending");

   // The marked character is always the newline.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> (rsp_text_byte == btda_pkg::ASCII_NEWLINE))
      else $error("last character is not a newline");

   // Every other character is a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |->
         (rsp_text_byte[7:4] == btda_pkg::ASCII_DIGIT_HI && rsp_text_byte[3:0] <= 4'd9))
      else $error("character is not a decimal digit");

   // Delivery of the newline returns the block to intake.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_char) |=> (!rsp_valid && !req_stall))
      else $error("block did not return to idle after the newline");

   // An accepted item is first converted before any character appears.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("character shown before conversion");
`endif

endmodule

`default_nettype wire

// File: rtl/btda_datapath.sv
// Datapath of the binary to decimal ASCII converter: bit-serial double
// dabble into packed decimal digits, then digit-by-digit read-out.
// Depends on btda_pkg for widths, character codes and the command structs.
`default_nettype none

module btda_datapath #(
   parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire btda_pkg::btda_cmd_type           cmd,
   input  wire logic [btda_pkg::NUMBER_WIDTH-1:0] number,
   output btda_pkg::btda_stat_type               stat,
   output logic      [btda_pkg::TEXT_WIDTH-1:0]   text_byte
);

   // Bits of the input that are converted; bits above the field are ignored.
   localparam int EFF_BITS = (VALUE_BITS < btda_pkg::NUMBER_WIDTH) ?
                             VALUE_BITS : btda_pkg::NUMBER_WIDTH;
   // Decimal digits needed for the largest value: floor(bits * log10(2)) + 1.
   localparam int DIGITS    = ((EFF_BITS * 1233) >> 12) + 1;
   localparam int DW        = btda_pkg::DIGIT_WIDTH;
   localparam int BCD_W     = DW * DIGITS;
   localparam int BIT_CNT_W = $clog2(EFF_BITS + 1);
   localparam int DIG_CNT_W = $clog2(DIGITS + 1);

   logic [EFF_BITS-1:0]  bin_ff,     bin_in;
   logic [BCD_W-1:0]     bcd_ff,     bcd_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic [BCD_W-1:0]     bcd_adj;
   logic [DW-1:0]        top_digit;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[DW*i +: DW] >= DW'(5)) begin
            bcd_adj[DW*i +: DW] = bcd_ff[DW*i +: DW] + DW'(3);
         end else begin
            bcd_adj[DW*i +: DW] = bcd_ff[DW*i +: DW];
         end
      end
   end

   // Next values of the conversion registers and counters.
   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      if (cmd.load) begin
         bin_in     = number[EFF_BITS-1:0];
         bcd_in     = '0;
         bit_cnt_in = BIT_CNT_W'(EFF_BITS);
         dig_cnt_in = DIG_CNT_W'(DIGITS);
      end else if (cmd.dabble) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[EFF_BITS-1]};
         bin_in     = {bin_ff[EFF_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
      end else if (cmd.shift) begin
         bcd_in     = {bcd_ff[BCD_W-DW-1:0], {DW{1'b0}}};
         dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
      end
   end

   // Counters are control state; the value registers need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   // Status for the controller and the character on the result channel.
   assign top_digit     = bcd_ff[BCD_W-1 -: DW];
   assign stat.bits_last = (bit_cnt_ff == BIT_CNT_W'(1));
   assign stat.top_zero  = (top_digit == '0);
   assign stat.one_left  = (dig_cnt_ff == DIG_CNT_W'(1));
   assign text_byte     = cmd.newline_sel ? btda_pkg::ASCII_NEWLINE :
                          {btda_pkg::ASCII_DIGIT_HI, top_digit};

endmodule

`default_nettype wire

// File: rtl/btda_ctrl.sv
// Controller of the binary to decimal ASCII converter: sequences intake,
// conversion, leading-zero removal and the output of each character.
// Depends on btda_pkg for the state type and the command and status structs.
`default_nettype none

module btda_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire btda_pkg::btda_stat_type stat,
   output btda_pkg::btda_cmd_type       cmd
);

   btda_pkg::btda_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btda_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = btda_pkg::ST_CONVERT;
            end
         end
         btda_pkg::ST_CONVERT: begin
            if (stat.bits_last) begin
               state_in = btda_pkg::ST_SKIP;
            end
         end
         btda_pkg::ST_SKIP: begin
            if (!stat.top_zero || stat.one_left) begin
               state_in = btda_pkg::ST_EMIT;
            end
         end
         btda_pkg::ST_EMIT: begin
            if (!rsp_stall && stat.one_left) begin
               state_in = btda_pkg::ST_NEWLINE;
            end
         end
         btda_pkg::ST_NEWLINE: begin
            if (!rsp_stall) begin
               state_in = btda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btda_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands for each state.
   always_comb begin
      req_stall       = 1'b1;
      rsp_valid       = 1'b0;
      cmd.load        = 1'b0;
      cmd.dabble      = 1'b0;
      cmd.shift       = 1'b0;
      cmd.newline_sel = 1'b0;
      case (state_ff)
         btda_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         btda_pkg::ST_CONVERT: begin
            cmd.dabble = 1'b1;
         end
         btda_pkg::ST_SKIP: begin
            cmd.shift = stat.top_zero && !stat.one_left;
         end
         btda_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.shift = !rsp_stall;
         end
         btda_pkg::ST_NEWLINE: begin
            rsp_valid       = 1'b1;
            cmd.newline_sel = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: test/tb_binary_to_decimal_ascii.sv
// Testbench for binary_to_decimal_ascii: sends unsigned values, predicts their decimal text
// and checks every character item against the prediction in order.
// Depends on btda_pkg and the binary_to_decimal_ascii top level.
module tb_binary_to_decimal_ascii;

   localparam int VALUE_BITS     = btda_pkg::VALUE_BITS_DEFAULT;
   localparam int NUMBER_WIDTH   = btda_pkg::NUMBER_WIDTH;
   localparam int TEXT_WIDTH     = btda_pkg::TEXT_WIDTH;
   localparam int RANDOM_ITEMS   = 350;
   localparam int QUIET_ITEMS    = 60;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 60;
   localparam int TIMEOUT_UNITS  = 2_400_000;

   // One character of the expected text.
   typedef struct {
      logic [TEXT_WIDTH-1:0] text_byte;
      logic                  last_char;
   } text_char_type;

   // Predicts the decimal text of each accepted value and checks the characters in order.
   class text_scoreboard;
      text_char_type expected_chars[$];
      int            failures;

      function new();
         failures = 0;
      endfunction

      // Render one accepted value as decimal digits and a closing newline.
      function void note_number(input logic [NUMBER_WIDTH-1:0] number);
         logic [63:0]   value;
         logic [63:0]   value_mask;
         logic [3:0]    digit_stack[$];
         text_char_type next_char;
         value_mask = (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
         value = {32'd0, number} & value_mask;
         do begin
            digit_stack.push_front(4'(value % 64'd10));
            value = value / 64'd10;
         end while (value != 64'd0);
         foreach (digit_stack[i]) begin
            next_char.text_byte = {btda_pkg::ASCII_DIGIT_HI, digit_stack[i]};
            next_char.last_char = 1'b0;
            expected_chars.push_back(next_char);
         end
         next_char.text_byte = btda_pkg::ASCII_NEWLINE;
         next_char.last_char = 1'b1;
         expected_chars.push_back(next_char);
      endfunction

      // Compare one delivered character with the oldest expectation.
      function void check_char(input logic [TEXT_WIDTH-1:0] text_byte, input logic last_char);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("Unexpected character: text_byte %h last_char %b", text_byte, last_char);
         end else begin
            want = expected_chars.pop_front();
            if (text_byte !== want.text_byte || last_char !== want.last_char) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("Mismatch: expected text_byte %h last_char %b, got %h %b",
                           want.text_byte, want.last_char, text_byte, last_char);
            end
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // Characters still waiting at the end are failures.
      function void check_leftover();
         if (expected_chars.size() != 0) begin
            failures++;
            $display("%0d expected characters never arrived", expected_chars.size());
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [NUMBER_WIDTH-1:0] req_number = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [TEXT_WIDTH-1:0]   rsp_text_byte;
   logic                    rsp_last_char;
   bit                      idle_enable = 1'b1;

   text_scoreboard text_sb = new();

   binary_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_text_byte(rsp_text_byte),
      .rsp_last_char(rsp_last_char)
   );

   always #6 clock = ~clock;

   // Note accepted values and check delivered characters at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            text_sb.note_number(req_number);
         if (rsp_valid && !rsp_stall)
            text_sb.check_char(rsp_text_byte, rsp_last_char);
      end
   end

   // Receiver stalls in random bursts while idling is enabled.
   initial begin
      int stall_len;
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(3, 0) == 0) begin
            stall_len = $urandom_range(8, 1);
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Present one value and hold it until it is accepted, then perhaps leave a gap.
   task automatic send_number(input logic [NUMBER_WIDTH-1:0] number);
      int gap_len;
      req_valid  <= 1'b1;
      req_number <= number;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (idle_enable && $urandom_range(2, 0) == 0) begin
         gap_len = $urandom_range(8, 1);
         req_valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected character has been delivered.
   task automatic wait_for_text;
      req_valid <= 1'b0;
      @(posedge clock);
      while (text_sb.pending() != 0) @(posedge clock);
   endtask

   // Random values spread over every digit count, with small values and decade edges.
   function automatic logic [NUMBER_WIDTH-1:0] random_number();
      int                      digits;
      longint unsigned         low_bound;
      longint unsigned         high_bound;
      logic [NUMBER_WIDTH-1:0] number;
      case ($urandom_range(3, 0))
         0: begin
            number = $urandom;
         end
         1: begin
            digits = $urandom_range(10, 1);
            low_bound = 1;
            repeat (digits - 1) low_bound = low_bound * 10;
            high_bound = low_bound * 10 - 1;
            if (high_bound > 64'hFFFF_FFFF) high_bound = 64'hFFFF_FFFF;
            if (digits == 1) low_bound = 0;
            number = $urandom_range(high_bound[31:0], low_bound[31:0]);
         end
         2: begin
            number = $urandom_range(20, 0);
         end
         default: begin
            digits = $urandom_range(9, 1);
            low_bound = 1;
            repeat (digits) low_bound = low_bound * 10;
            number = low_bound[31:0] - 32'd1 + $urandom_range(2, 0);
         end
      endcase
      return number;
   endfunction

   // Main sequence: reset, directed values, random values, then drain and report.
   initial begin
      logic [NUMBER_WIDTH-1:0] directed_values[];
      directed_values = '{
         32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999, 32'd1000,
         32'd65535, 32'd100000, 32'd999999, 32'd10000000, 32'd999999999,
         32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
         32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: edges of the field and of each digit count.
      foreach (directed_values[i])
         send_number(directed_values[i]);

      // The sender pauses until the text of every value has arrived.
      wait_for_text();

      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         if (item == RANDOM_ITEMS / 2)
            wait_for_text();
         if (item == RANDOM_ITEMS - QUIET_ITEMS)
            idle_enable = 1'b0;
         send_number(random_number());
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray character.
      while (text_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      text_sb.check_leftover();
      if (text_sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog for a block that stops delivering.
   initial begin
      #(TIMEOUT_UNITS);
      $display("Some tests failed");
      $finish;
   end

endmodule
